@@ hw/rtl/rbfi_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rbfi_pkg
// Shared constants, types and a helper function of the random bit fault
// injector: generator constants, register indexes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package rbfi_pkg;

    localparam int DATA_BITS_DEF = 8;
    localparam int BYTE_W        = 8;
    localparam int RATIO_W       = 32;
    localparam int STATE_W       = 64;
    localparam int DRAW_W        = 32;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 64;

    localparam logic [STATE_W-1:0] PCG_MUL = 64'd6364136223846793005;
    localparam logic [STATE_W-1:0] PCG_INC = 64'd1442695040888963407;
    // Reset state: a seed of zero, advanced once.
    localparam logic [STATE_W-1:0] RESET_STATE = PCG_INC * PCG_MUL + PCG_INC;

    localparam logic [RATIO_W-1:0] RATIO_RESET = 32'd1000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEED,
        ST_BIT,
        ST_REPL
    } t_state;

    typedef struct packed {
        logic lcg_start;
        logic mod_start;
        logic take_in;
        logic rec_bit;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic lcg_busy;
        logic mod_busy;
        logic last_bit;
    } t_sts;

    // XSH-RR output of a generator state
    function automatic logic [DRAW_W-1:0] pcg_out(input logic [STATE_W-1:0] x);
        logic [STATE_W-1:0]  xs;
        logic [DRAW_W-1:0]   v;
        logic [4:0]          rot;
        logic [2*DRAW_W-1:0] dbl;
        rot = x[63:59];
        xs  = x ^ (x >> 18);
        v   = xs[58:27];
        dbl = {v, v} >> rot;
        return dbl[DRAW_W-1:0];
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/random_bit_fault_injector.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// random_bit_fault_injector
// Passes bytes through with randomly chosen bits replaced by random values.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis carries one data byte per transfer. Output stream
//   m_axis returns one transfer per input byte: the corrupted byte and a mask
//   of the replaced bit positions.
//   A PCG32 generator (64-bit LCG, XSH-RR output) makes DATA_BITS draws per
//   byte; bit i is replaced when draw i modulo the ratio register is zero.
//   One more draw supplies the replacement values.
//   Rate: the remainder unit (four bits per cycle) sets the pace of the
//   per-bit loop, with the next LCG step overlapped. A new byte is taken
//   only once the previous result is in the output register.
//   The output register holds a finished result while the receiver stalls;
//   the next byte is taken and processed meanwhile and waits at its end
//   until the output register is free.
//   Configuration: ratio (index 0) and seed (index 1) are written through
//   i_cfg_*. A seed write loads seed plus increment and advances the
//   generator once, which blocks input while it advances.
//   Reset: ratio returns to 1000 and the generator to the zero-seed state.
// ----------------------------------------------------------------------------
module random_bit_fault_injector #(
    parameter int DATA_BITS = rbfi_pkg::DATA_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration write port
    input  wire logic                            i_cfg_we,
    input  wire logic [rbfi_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rbfi_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
    // output stream
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [15:0]                          m_axis_tdata   // [7:0] out_byte,
                                                                // [15:8] replace_mask
);

    rbfi_pkg::t_cmd cmd;
    rbfi_pkg::t_sts sts;
    logic [rbfi_pkg::BYTE_W-1:0] out_byte;
    logic [rbfi_pkg::BYTE_W-1:0] replace_mask;

    // Sequence the draws and the handshakes
    rbfi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_sts       (sts),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    // Generator, remainder unit and result registers
    rbfi_dp #(
        .DATA_BITS (DATA_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_data_byte    (s_axis_tdata),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_byte     (out_byte),
        .o_replace_mask (replace_mask)
    );

    assign m_axis_tdata = {replace_mask, out_byte};

endmodule
`default_nettype wire

@@ hw/rtl/rbfi_lcg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rbfi_lcg
// 64-bit LCG state with one shared 32x32 multiplier. A step runs through the
// phases low product, two cross products, then the sum with the increment.
// ----------------------------------------------------------------------------
module rbfi_lcg (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_load,
    input  wire logic [rbfi_pkg::STATE_W-1:0] i_load_val,
    input  wire logic                         i_start,
    output logic                              o_busy,
    output logic [rbfi_pkg::DRAW_W-1:0]       o_draw,
    output logic [rbfi_pkg::DRAW_W-1:0]       o_draw_now
);

    localparam logic [1:0] PH_LO     = 2'd0;
    localparam logic [1:0] PH_CROSS1 = 2'd1;
    localparam logic [1:0] PH_CROSS2 = 2'd2;
    localparam logic [1:0] PH_SUM    = 2'd3;

    logic [rbfi_pkg::STATE_W-1:0] r_state;
    logic [rbfi_pkg::STATE_W-1:0] r_acc;
    logic [rbfi_pkg::STATE_W-1:0] r_prod;
    logic [rbfi_pkg::DRAW_W-1:0]  r_draw;
    logic [1:0]                   r_phase;
    logic                         r_busy;

    logic [31:0]                  mul_a;
    logic [31:0]                  mul_b;
    logic [63:0]                  mul_p;
    logic [31:0]                  hi_sum;
    logic                         go;

    assign go     = i_start && !r_busy && !i_load;
    assign mul_a  = (r_phase == PH_CROSS2) ? r_state[63:32] : r_state[31:0];
    assign mul_b  = (r_phase == PH_CROSS1) ? rbfi_pkg::PCG_MUL[63:32]
                                           : rbfi_pkg::PCG_MUL[31:0];
    assign mul_p  = mul_a * mul_b;
    assign hi_sum = r_acc[63:32] + r_prod[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rbfi_pkg::RESET_STATE;
            r_busy  <= 1'b0;
            r_phase <= PH_LO;
        end else if (i_load) begin
            r_state <= i_load_val;
            r_busy  <= 1'b0;
            r_phase <= PH_LO;
        end else if (go) begin
            r_busy  <= 1'b1;
            r_phase <= PH_LO;
        end else if (r_busy) begin
            r_phase <= r_phase + 2'd1;
            if (r_phase == PH_SUM) begin
                r_state <= {hi_sum, r_acc[31:0]} + rbfi_pkg::PCG_INC;
                r_busy  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_draw <= rbfi_pkg::pcg_out(r_state);
        end
        if (r_busy) begin
            unique case (r_phase)
                PH_LO: begin
                    r_prod <= mul_p;
                end
                PH_CROSS1: begin
                    r_acc  <= r_prod;
                    r_prod <= mul_p;
                end
                PH_CROSS2: begin
                    r_acc[63:32] <= hi_sum;
                    r_prod       <= mul_p;
                end
                PH_SUM: begin
                end
                default: begin
                end
            endcase
        end
    end

    assign o_busy     = r_busy;
    assign o_draw     = r_draw;
    assign o_draw_now = rbfi_pkg::pcg_out(r_state);

endmodule
`default_nettype wire

@@ hw/rtl/rbfi_mod.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rbfi_mod
// 32-bit remainder unit, restoring, four dividend bits per cycle.
// Flags a zero remainder.
// ----------------------------------------------------------------------------
module rbfi_mod (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [rbfi_pkg::DRAW_W-1:0]  i_dividend,
    input  wire logic [rbfi_pkg::RATIO_W-1:0] i_divisor,
    output logic                              o_busy,
    output logic                              o_zero
);

    localparam int         BITS_PER_CYC = 4;
    localparam logic [2:0] LAST_ITER    = 3'(rbfi_pkg::DRAW_W / BITS_PER_CYC - 1);

    logic [rbfi_pkg::RATIO_W-1:0] r_rem;
    logic [rbfi_pkg::DRAW_W-1:0]  r_dvd;
    logic [rbfi_pkg::RATIO_W-1:0] r_div;
    logic [2:0]                   r_cnt;
    logic                         r_busy;

    logic [rbfi_pkg::RATIO_W-1:0] n_rem;
    logic [rbfi_pkg::DRAW_W-1:0]  n_dvd;

    always_comb begin
        logic [rbfi_pkg::RATIO_W:0] t;
        n_rem = r_rem;
        n_dvd = r_dvd;
        for (int k = 0; k < BITS_PER_CYC; k++) begin
            t     = {n_rem, n_dvd[rbfi_pkg::DRAW_W-1]};
            n_dvd = n_dvd << 1;
            if (t >= {1'b0, r_div}) begin
                t = t - {1'b0, r_div};
            end
            n_rem = t[rbfi_pkg::RATIO_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start && !r_busy) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 3'd1;
            if (r_cnt == LAST_ITER) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= n_dvd;
        end
    end

    assign o_busy = r_busy;
    assign o_zero = (r_rem == '0);

endmodule
`default_nettype wire

@@ hw/rtl/rbfi_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rbfi_dp
// Datapath: configuration registers, generator, remainder unit, bit counter,
// selection mask and the output register.
// ----------------------------------------------------------------------------
module rbfi_dp #(
    parameter int DATA_BITS = rbfi_pkg::DATA_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [rbfi_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rbfi_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [rbfi_pkg::BYTE_W-1:0]     i_data_byte,
    input  wire rbfi_pkg::t_cmd                  i_cmd,
    output rbfi_pkg::t_sts                       o_sts,
    output logic [rbfi_pkg::BYTE_W-1:0]          o_out_byte,
    output logic [rbfi_pkg::BYTE_W-1:0]          o_replace_mask
);

    localparam int IDX_W = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DATA_BITS - 1);
    localparam logic [rbfi_pkg::BYTE_W-1:0] WIDTH_MASK =
        (DATA_BITS >= rbfi_pkg::BYTE_W) ? 8'hFF : 8'((16'd1 << DATA_BITS) - 16'd1);

    logic [rbfi_pkg::RATIO_W-1:0] r_ratio;
    logic [IDX_W-1:0]             r_idx;
    logic [rbfi_pkg::BYTE_W-1:0]  r_data;
    logic [rbfi_pkg::BYTE_W-1:0]  r_sel;
    logic [rbfi_pkg::BYTE_W-1:0]  r_out_byte;
    logic [rbfi_pkg::BYTE_W-1:0]  r_out_mask;

    logic [rbfi_pkg::BYTE_W-1:0]  n_sel;
    logic [rbfi_pkg::RATIO_W-1:0] eff_ratio;
    logic                         seed_load;
    logic                         lcg_busy;
    logic                         mod_busy;
    logic                         mod_zero;
    logic [rbfi_pkg::DRAW_W-1:0]  draw;
    logic [rbfi_pkg::DRAW_W-1:0]  draw_now;

    assign seed_load = i_cfg_we && (i_cfg_idx == rbfi_pkg::CFG_SEED);
    assign eff_ratio = (r_ratio == '0) ? 32'd1 : r_ratio;

    rbfi_lcg u_lcg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (seed_load),
        .i_load_val (i_cfg_data + rbfi_pkg::PCG_INC),
        .i_start    (i_cmd.lcg_start),
        .o_busy     (lcg_busy),
        .o_draw     (draw),
        .o_draw_now (draw_now)
    );

    rbfi_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.mod_start),
        .i_dividend (draw_now),
        .i_divisor  (eff_ratio),
        .o_busy     (mod_busy),
        .o_zero     (mod_zero)
    );

    // Only the low byte of the mask is visible; higher bit positions still
    // consume a draw but are not kept.
    always_comb begin
        n_sel = r_sel;
        for (int j = 0; j < rbfi_pkg::BYTE_W; j++) begin
            if ((32'(r_idx) == j) && mod_zero) begin
                n_sel[j] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= rbfi_pkg::RATIO_RESET;
            r_idx   <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == rbfi_pkg::CFG_RATIO)) begin
                r_ratio <= i_cfg_data[rbfi_pkg::RATIO_W-1:0];
            end
            if (i_cmd.take_in) begin
                r_idx <= '0;
            end else if (i_cmd.rec_bit) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_data <= i_data_byte & WIDTH_MASK;
            r_sel  <= '0;
        end else if (i_cmd.rec_bit) begin
            r_sel <= n_sel;
        end
        if (i_cmd.load_out) begin
            r_out_byte <= (r_sel & draw[rbfi_pkg::BYTE_W-1:0]) | (~r_sel & r_data);
            r_out_mask <= r_sel;
        end
    end

    assign o_sts.lcg_busy = lcg_busy;
    assign o_sts.mod_busy = mod_busy;
    assign o_sts.last_bit = (r_idx == LAST_IDX);
    assign o_out_byte     = r_out_byte;
    assign o_replace_mask = r_out_mask;

endmodule
`default_nettype wire

@@ hw/rtl/rbfi_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rbfi_ctrl
// Controller: sequences the per-bit draws, the replacement draw, the reseed
// step and the output handshake.
// ----------------------------------------------------------------------------
module rbfi_ctrl (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [rbfi_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire rbfi_pkg::t_sts                 i_sts,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output rbfi_pkg::t_cmd                      o_cmd
);

    rbfi_pkg::t_state r_state;
    rbfi_pkg::t_state n_state;
    logic             r_seed_pend;
    logic             n_seed_pend;
    logic             r_ovalid;
    logic             n_ovalid;
    logic             pend_clr;
    logic             both_done;
    logic             out_free;

    assign both_done = !i_sts.lcg_busy && !i_sts.mod_busy;
    assign out_free  = !r_ovalid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rbfi_pkg::ST_IDLE: begin
                if (r_seed_pend) begin
                    n_state = rbfi_pkg::ST_SEED;
                end else if (i_in_valid) begin
                    n_state = rbfi_pkg::ST_BIT;
                end
            end
            rbfi_pkg::ST_SEED: begin
                if (!i_sts.lcg_busy) begin
                    n_state = rbfi_pkg::ST_IDLE;
                end
            end
            rbfi_pkg::ST_BIT: begin
                if (both_done && i_sts.last_bit) begin
                    n_state = rbfi_pkg::ST_REPL;
                end
            end
            rbfi_pkg::ST_REPL: begin
                if (!i_sts.lcg_busy && out_free) begin
                    n_state = rbfi_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rbfi_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        pend_clr   = 1'b0;
        o_in_ready = 1'b0;
        unique case (r_state)
            rbfi_pkg::ST_IDLE: begin
                o_in_ready = !r_seed_pend;
                if (r_seed_pend) begin
                    o_cmd.lcg_start = 1'b1;
                    pend_clr        = 1'b1;
                end else if (i_in_valid) begin
                    o_cmd.take_in   = 1'b1;
                    o_cmd.lcg_start = 1'b1;
                    o_cmd.mod_start = 1'b1;
                end
            end
            rbfi_pkg::ST_SEED: begin
            end
            rbfi_pkg::ST_BIT: begin
                if (both_done) begin
                    o_cmd.rec_bit   = 1'b1;
                    o_cmd.lcg_start = 1'b1;
                    o_cmd.mod_start = !i_sts.last_bit;
                end
            end
            rbfi_pkg::ST_REPL: begin
                o_cmd.load_out = !i_sts.lcg_busy && out_free;
            end
            default: begin
            end
        endcase
    end

    // A seed write wins over the clear, so a write that aborts a step restarts it.
    assign n_seed_pend = (i_cfg_we && (i_cfg_idx == rbfi_pkg::CFG_SEED)) ||
                         (r_seed_pend && !pend_clr);
    assign n_ovalid    = o_cmd.load_out || (r_ovalid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rbfi_pkg::ST_IDLE;
            r_seed_pend <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seed_pend <= n_seed_pend;
            r_ovalid    <= n_ovalid;
        end
    end

    assign o_out_valid = r_ovalid;

endmodule
`default_nettype wire

@@ hw/rtl/rbfi_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rbfi_checker
// Port-level checks of the fault injector, bound to the top level.
// ----------------------------------------------------------------------------
module rbfi_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_cfg_we,
    input wire logic [rbfi_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [15:0]                     m_axis_tdata
);

    // A stalled result stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    // A stalled result keeps its data
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("output data changed while stalled");

    // One byte at a time: no second transfer right after an input transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while a byte is in work");

    // A seed write holds off input: no input is ready straight after it
    a_seed_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_idx == rbfi_pkg::CFG_SEED)) |=> !s_axis_tready)
        else $error("input taken during reseed");

    // A result never appears straight after an input transfer
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
        else $error("result shown too early");

endmodule

bind random_bit_fault_injector rbfi_checker u_rbfi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_we      (i_cfg_we),
    .i_cfg_idx     (i_cfg_idx),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
